// ===== rtl/oli_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list package
// Holds the shared types, the size of the list and the operation, status and
// cell control codes.
// ----------------------------------------------------------------------------
package oli_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;

    localparam logic [1:0] OP_INSERT_HEAD = 2'd0;
    localparam logic [1:0] OP_INSERT_POS  = 2'd1;
    localparam logic [1:0] OP_DELETE_LAST = 2'd2;
    localparam logic [1:0] OP_TRAVERSE    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_ROTATE = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
        logic [7:0]         position;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] element;
        logic [1:0]         status;
        logic [CNT_W-1:0]   entries_held;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] ins_idx;
        logic [IDX_W-1:0] tail_idx;
    } cell_ctrl_t;

endpackage

// ===== rtl/ordered_list_insert_delete_core.sv =====
// ----------------------------------------------------------------------------
// Ordered list insert/delete core
// Keeps an ordered list of up to 16 signed values in a row of cells and
// serves insert, delete-last and traverse requests.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel and results leave on the m_ channel, both
// with valid/ready handshakes and packed struct payloads.
// Insert at head, insert at position and delete last each give one result,
// registered in the cycle after the request is taken; a new request can be
// taken every cycle while no traverse runs and the receiver keeps up.
// A traverse of a list holding N entries gives one result per entry, as the
// chain of cells rotates towards the head and the head cell is read out.
// An empty list gives a single empty-status result.
// The list is back in its original order when the traverse ends.
// While the receiver stalls, the output register holds its result, a traverse
// pauses and no new request is taken once that register is full.
// Reset empties the list and clears the handshake state; the stored entries
// are not cleared, as only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core
    import oli_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TRAV = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] trav_idx_reg;
    logic [CNT_W-1:0] trav_idx_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_item_reg;
    out_item_t        m_item_next;

    cell_ctrl_t         ctrl;
    logic signed [31:0] cell_data [DEPTH];

    logic             out_free;
    logic             accept;
    logic             full;
    logic [8:0]       pos_w;
    logic [8:0]       cnt_plus;
    logic [CNT_W-1:0] trav_idx_inc;

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == S_IDLE) && out_free;
    assign accept       = s_valid && s_ready;
    assign full         = (count_reg == CNT_W'(DEPTH));
    assign pos_w        = {1'b0, s_item.position};
    assign cnt_plus     = 9'(count_reg) + 9'd1;
    assign trav_idx_inc = trav_idx_reg + CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        trav_idx_next = trav_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;
        ctrl.cmd      = CELL_HOLD;
        ctrl.ins_idx  = '0;
        ctrl.tail_idx = IDX_W'(count_reg - CNT_W'(1));

        if (accept) begin
            m_item_next.element = '0;
            m_item_next.last    = 1'b1;
            m_item_next.status  = ST_OK;
            case (s_item.operation)
                OP_INSERT_HEAD: begin
                    if (full) begin
                        m_item_next.status = ST_FULL;
                    end else begin
                        ctrl.cmd   = CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_INSERT_POS: begin
                    if (pos_w == 9'd0 || pos_w > cnt_plus) begin
                        m_item_next.status = ST_RANGE;
                    end else if (full) begin
                        m_item_next.status = ST_FULL;
                    end else begin
                        ctrl.cmd     = CELL_INSERT;
                        ctrl.ins_idx = IDX_W'(s_item.position - 8'd1);
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                OP_DELETE_LAST: begin
                    if (count_reg == '0) begin
                        m_item_next.status = ST_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    if (count_reg == '0) begin
                        m_item_next.status = ST_EMPTY;
                    end
                end
            endcase
            m_item_next.entries_held = count_next;
            if (s_item.operation == OP_TRAVERSE && count_reg != '0) begin
                m_valid_next  = 1'b0;
                state_next    = S_TRAV;
                trav_idx_next = '0;
            end else begin
                m_valid_next = 1'b1;
            end
        end else if (state_reg == S_TRAV && out_free) begin
            ctrl.cmd                 = CELL_ROTATE;
            m_valid_next             = 1'b1;
            m_item_next.element      = cell_data[0];
            m_item_next.status       = ST_OK;
            m_item_next.entries_held = count_reg;
            m_item_next.last         = (trav_idx_inc == count_reg);
            trav_idx_next            = trav_idx_inc;
            if (trav_idx_inc == count_reg) begin
                state_next = S_IDLE;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] left_in;
        logic signed [31:0] right_in;

        if (g == 0) begin : g_head
            assign left_in = s_item.value;
        end else begin : g_body
            assign left_in = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_in = cell_data[0];
        end else begin : g_inner
            assign right_in = cell_data[g+1];
        end

        oli_cell #(
            .IDX(g)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .new_value  (s_item.value),
            .left_data  (left_in),
            .right_data (right_in),
            .head_data  (cell_data[0]),
            .entry      (cell_data[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            trav_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            trav_idx_reg <= trav_idx_next;
            m_valid_reg  <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== rtl/oli_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry. On an insert it takes the new value or its left
// neighbour's entry; on a traverse step it takes its right neighbour's entry,
// or the head entry when it is the tail of the list.
// ----------------------------------------------------------------------------
module oli_cell
    import oli_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic signed [31:0] new_value,
    input  logic signed [31:0] left_data,
    input  logic signed [31:0] right_data,
    input  logic signed [31:0] head_data,
    output logic signed [31:0] entry
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.cmd)
            CELL_INSERT: begin
                if (MY_IDX == ctrl.ins_idx) begin
                    entry_next = new_value;
                end else if (MY_IDX > ctrl.ins_idx) begin
                    entry_next = left_data;
                end
            end
            CELL_ROTATE: begin
                if (MY_IDX == ctrl.tail_idx) begin
                    entry_next = head_data;
                end else if (MY_IDX < ctrl.tail_idx) begin
                    entry_next = right_data;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
